>>> sv/axrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axrb_pkg: shared types and constants
// Phase encoding, error codes and the per-tick result record of the AXI read
// burst slave.
// ----------------------------------------------------------------------------
package axrb_pkg;

    // Fixed widths of the stream fields
    localparam int AddrFieldW = 32;
    localparam int DataFieldW = 32;
    localparam int LenW       = 8;
    localparam int SizeW      = 3;
    localparam int BurstW     = 2;
    localparam int ErrW       = 2;

    // Widest beat is 2^7 bytes; alignment check looks at this many low bits
    localparam int AlignW     = 7;

    localparam logic [BurstW-1:0] BURST_INCR = 2'd1;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNALIGNED = 2'd1,
        ERR_NOT_INCR  = 2'd2,
        ERR_NARROW    = 2'd3
    } t_err;

    typedef enum logic {
        PH_ADDR = 1'b0,
        PH_DATA = 1'b1
    } t_phase;

    // One tick of sampled bus inputs
    typedef struct packed {
        logic                  ar_valid;
        logic [AddrFieldW-1:0] ar_addr;
        logic [LenW-1:0]       ar_len;
        logic [SizeW-1:0]      ar_size;
        logic [BurstW-1:0]     ar_burst;
        logic                  r_ready;
        logic [DataFieldW-1:0] mem_read_data;
    } t_tick_in;

    // One tick of block outputs
    typedef struct packed {
        logic                  ar_ready;
        logic                  r_valid;
        logic                  r_last;
        logic [DataFieldW-1:0] r_data;
        logic                  mem_read_en;
        logic [AddrFieldW-1:0] mem_read_addr;
        t_err                  error_code;
    } t_tick_out;

endpackage

>>> sv/axrb_addr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axrb_addr_chk: read address checker
// Checks alignment, burst type and beat size of a read address; the first
// failing check sets the error code.
// ----------------------------------------------------------------------------
module axrb_addr_chk
    import axrb_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic [AddrFieldW-1:0] i_ar_addr,
    input  logic [SizeW-1:0]      i_ar_size,
    input  logic [BurstW-1:0]     i_ar_burst,
    output t_err                  o_err
);

    localparam int BytesPerBeat = DATA_WIDTH / 8;

    logic [AlignW:0]   w_nbytes;
    logic [AlignW-1:0] w_mask;
    logic              w_unaligned;

    assign w_nbytes    = (AlignW + 1)'(1) << i_ar_size;
    assign w_mask      = AlignW'(w_nbytes - (AlignW + 1)'(1));
    assign w_unaligned = (i_ar_addr[AlignW-1:0] & w_mask) != '0;

    always_comb begin
        priority if (w_unaligned) begin
            o_err = ERR_UNALIGNED;
        end else if (i_ar_burst != BURST_INCR) begin
            o_err = ERR_NOT_INCR;
        end else if (w_nbytes != (AlignW + 1)'(BytesPerBeat)) begin
            o_err = ERR_NARROW;
        end else begin
            o_err = ERR_NONE;
        end
    end

endmodule

>>> sv/axrb_beat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axrb_beat_ctrl: address/data phase control
// Holds the phase, beat counter, beat address and registered read channel
// signals; advances one bus tick per step.
// ----------------------------------------------------------------------------
module axrb_beat_ctrl
    import axrb_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_tick_in  i_tick,
    output t_tick_out o_tick
);

    localparam int BytesPerBeat = DATA_WIDTH / 8;
    // Bits above the 32-bit fields never reach an output
    localparam int AddrKeep = (ADDR_WIDTH < AddrFieldW) ? ADDR_WIDTH : AddrFieldW;
    localparam int DataKeep = (DATA_WIDTH < DataFieldW) ? DATA_WIDTH : DataFieldW;

    t_phase              r_phase, n_phase;
    logic [LenW-1:0]     r_beats, n_beats;
    logic [AddrKeep-1:0] r_addr, n_addr;
    logic                r_ar_ready, n_ar_ready;
    logic                r_r_valid, n_r_valid;
    logic                r_r_last, n_r_last;
    logic [DataKeep-1:0] r_r_data, n_r_data;

    t_err                w_chk_err;
    logic                w_addr_hs;
    logic                w_addr_take;
    logic                w_data_hs;
    logic                w_last_beat;
    logic                w_next_beat;
    logic                w_rd_en;
    logic [AddrKeep-1:0] w_rd_addr;

    axrb_addr_chk #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chk (
        .i_ar_addr  (i_tick.ar_addr),
        .i_ar_size  (i_tick.ar_size),
        .i_ar_burst (i_tick.ar_burst),
        .o_err      (w_chk_err)
    );

    assign w_addr_hs   = (r_phase == PH_ADDR) && r_ar_ready && i_tick.ar_valid;
    assign w_addr_take = w_addr_hs && (w_chk_err == ERR_NONE);
    assign w_data_hs   = (r_phase == PH_DATA) && r_r_valid && i_tick.r_ready;
    assign w_last_beat = w_data_hs && (r_beats == '0);
    assign w_next_beat = w_data_hs && (r_beats != '0);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_ADDR: begin
                if (w_addr_take) n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (w_last_beat) n_phase = PH_ADDR;
            end
            default: n_phase = PH_ADDR;
        endcase
    end

    // Datapath and registered channel signals
    always_comb begin
        n_beats    = r_beats;
        n_addr     = r_addr;
        n_ar_ready = r_ar_ready;
        n_r_valid  = r_r_valid;
        n_r_last   = r_r_last;
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        unique case (r_phase)
            PH_ADDR: begin
                n_ar_ready = 1'b1;
                if (w_addr_take) begin
                    n_ar_ready = 1'b0;
                    n_beats    = i_tick.ar_len;
                    n_addr     = i_tick.ar_addr[AddrKeep-1:0];
                    n_r_last   = (i_tick.ar_len == '0);
                    w_rd_en    = 1'b1;
                    w_rd_addr  = i_tick.ar_addr[AddrKeep-1:0];
                end
            end
            PH_DATA: begin
                n_r_valid = 1'b1;
                if (w_last_beat) begin
                    n_r_valid = 1'b0;
                    n_r_last  = 1'b0;
                end else if (w_next_beat) begin
                    n_beats   = r_beats - LenW'(1);
                    n_addr    = r_addr + AddrKeep'(BytesPerBeat);
                    n_r_last  = (r_beats == LenW'(1));
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr + AddrKeep'(BytesPerBeat);
                end
            end
            default: ;
        endcase
        n_r_data = w_rd_en ? i_tick.mem_read_data[DataKeep-1:0] : r_r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ADDR;
            r_beats    <= '0;
            r_addr     <= '0;
            r_ar_ready <= 1'b0;
            r_r_valid  <= 1'b0;
            r_r_last   <= 1'b0;
            r_r_data   <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_beats    <= n_beats;
            r_addr     <= n_addr;
            r_ar_ready <= n_ar_ready;
            r_r_valid  <= n_r_valid;
            r_r_last   <= n_r_last;
            r_r_data   <= n_r_data;
        end
    end

    // Result of this tick: post-edge register values plus the memory request
    always_comb begin
        o_tick.ar_ready      = n_ar_ready;
        o_tick.r_valid       = n_r_valid;
        o_tick.r_last        = n_r_last;
        o_tick.r_data        = DataFieldW'(n_r_data);
        o_tick.mem_read_en   = w_rd_en;
        o_tick.mem_read_addr = AddrFieldW'(w_rd_addr);
        o_tick.error_code    = w_addr_hs ? w_chk_err : ERR_NONE;
    end

endmodule

>>> sv/axi_slave_read_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axi_slave_read_burst: AXI4 read slave, INCR bursts
// Each stream transaction is one bus tick; the block returns that tick's
// registered read-channel outputs, memory request and error code.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                          Per transaction
// s_axis   in   tvalid/tready/tdata[79:0]        one sampled bus tick
// m_axis   out  tvalid/tready/tdata[71:0]/tlast  one tick of outputs
//
// One transaction per cycle unless the output stalls; the result appears in
// the output register in the cycle after acceptance. The path is the address
// checker and beat address adder between input stream and output register.
// Reset (i_rst_n low, synchronous) returns to the address phase with the
// output stream empty. A stalled output holds its result; input is taken
// again as soon as that result is taken.
// ----------------------------------------------------------------------------
module axi_slave_read_burst
    import axrb_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] ar_valid, [32:1] ar_addr, [40:33] ar_len, [43:41] ar_size,
    // [45:44] ar_burst, [46] r_ready, [78:47] mem_read_data, [79] zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] ar_ready, [1] r_valid, [33:2] r_data, [34] mem_read_en,
    // [66:35] mem_read_addr, [68:67] error_code, [71:69] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_tick_in  w_tick_in;
    t_tick_out w_tick_out;
    logic      w_step;

    logic      r_out_valid;
    t_tick_out r_out;

    assign w_tick_in.ar_valid      = s_axis_tdata[0];
    assign w_tick_in.ar_addr       = s_axis_tdata[32:1];
    assign w_tick_in.ar_len        = s_axis_tdata[40:33];
    assign w_tick_in.ar_size       = s_axis_tdata[43:41];
    assign w_tick_in.ar_burst      = s_axis_tdata[45:44];
    assign w_tick_in.r_ready       = s_axis_tdata[46];
    assign w_tick_in.mem_read_data = s_axis_tdata[78:47];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    axrb_beat_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_tick  (w_tick_in),
        .o_tick  (w_tick_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_tick_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.r_last;
    assign m_axis_tdata  = {3'b000, r_out.error_code, r_out.mem_read_addr,
                            r_out.mem_read_en, r_out.r_data, r_out.r_valid,
                            r_out.ar_ready};

    // Address ready and read data valid are never raised together
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.ar_ready && r_out.r_valid))
        else $error("ar_ready and r_valid both high");

    // A rejected address never reads memory
    a_err_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != ERR_NONE) |-> !r_out.mem_read_en)
        else $error("memory read on rejected address");

    // Memory reads happen only while the address channel is closed
    a_read_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mem_read_en) |-> !r_out.ar_ready)
        else $error("memory read with ar_ready high");

endmodule

>>> sim/axi_slave_read_burst_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axi_slave_read_burst_test: self-checking bench for the AXI read burst slave
// Streams sampled bus ticks into the block. Each accepted tick is stepped
// through a cycle-level prediction of the read slave. Each returned tick of
// outputs is compared field by field with the oldest prediction. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module axi_slave_read_burst_test;
    import axrb_pkg::*;

    localparam int BeatBytes = DataFieldW / 8;

    typedef struct {
        t_tick_in tick;
        bit       hold;     // wait until all outstanding outputs are back
    } t_stim;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    axi_slave_read_burst i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the slave's state
    t_phase          phase      = PH_ADDR;
    logic [LenW-1:0] beats_left = '0;
    logic [31:0]     beat_addr  = '0;
    logic            ar_ready_q = 1'b0;
    logic            r_valid_q  = 1'b0;
    logic            r_last_q   = 1'b0;
    logic [31:0]     r_data_q   = '0;

    t_stim     tick_q[$];
    t_tick_out bus_outputs_q[$];
    t_tick_in  shown_tick;
    int        n_ticks;
    int        n_sent   = 0;
    int        n_errors = 0;
    int        tx_gap   = 0;
    int        tx_calls = 0;
    int        rx_stall = 0;
    int        rx_calls = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One bus tick of the read slave
    function automatic t_tick_out step_read_slave(input t_tick_in t);
        t_tick_out   res;
        logic        nxt_ar_ready;
        logic        nxt_r_valid;
        logic        nxt_r_last;
        logic        rd_en;
        logic [31:0] rd_addr;
        logic [31:0] align;
        t_err        err;
        nxt_ar_ready = ar_ready_q;
        nxt_r_valid  = r_valid_q;
        nxt_r_last   = r_last_q;
        rd_en        = 1'b0;
        rd_addr      = '0;
        err          = ERR_NONE;
        if (phase == PH_ADDR) begin
            nxt_ar_ready = 1'b1;
            if (ar_ready_q && t.ar_valid) begin
                align = (32'd1 << t.ar_size) - 32'd1;
                if ((t.ar_addr & align) != 0)
                    err = ERR_UNALIGNED;
                else if (t.ar_burst != BURST_INCR)
                    err = ERR_NOT_INCR;
                else if ((32'd1 << t.ar_size) != BeatBytes)
                    err = ERR_NARROW;
                if (err == ERR_NONE) begin
                    nxt_ar_ready = 1'b0;
                    beats_left   = t.ar_len;
                    beat_addr    = t.ar_addr;
                    phase        = PH_DATA;
                    nxt_r_last   = (t.ar_len == 0);
                    rd_en        = 1'b1;
                    rd_addr      = t.ar_addr;
                end
            end
        end else begin
            nxt_r_valid = 1'b1;
            if (t.r_ready && r_valid_q) begin
                if (beats_left == 0) begin
                    phase       = PH_ADDR;
                    nxt_r_valid = 1'b0;
                    nxt_r_last  = 1'b0;
                end else begin
                    beats_left = beats_left - 1'b1;
                    beat_addr  = beat_addr + 32'(BeatBytes);
                    rd_en      = 1'b1;
                    rd_addr    = beat_addr;
                    nxt_r_last = (beats_left == 0);
                end
            end
        end
        if (rd_en)
            r_data_q = t.mem_read_data;
        ar_ready_q = nxt_ar_ready;
        r_valid_q  = nxt_r_valid;
        r_last_q   = nxt_r_last;
        res.ar_ready      = ar_ready_q;
        res.r_valid       = r_valid_q;
        res.r_last        = r_last_q;
        res.r_data        = r_data_q;
        res.mem_read_en   = rd_en;
        res.mem_read_addr = rd_addr;
        res.error_code    = err;
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones; always back-to-back when calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_tick(input logic v, input logic [31:0] addr, input logic [7:0] len,
                            input logic [2:0] size, input logic [1:0] burst,
                            input logic rr, input bit hold);
        t_stim s;
        s.tick.ar_valid      = v;
        s.tick.ar_addr       = addr;
        s.tick.ar_len        = len;
        s.tick.ar_size       = size;
        s.tick.ar_burst      = burst;
        s.tick.r_ready       = rr;
        s.tick.mem_read_data = $urandom;
        s.hold               = hold;
        tick_q.push_back(s);
    endtask

    // Address request that fails one of the three checks
    task automatic add_bad_request();
        logic [2:0]  size;
        logic [31:0] mask;
        logic [31:0] addr;
        logic [1:0]  burst;
        int          kind;
        kind  = $urandom_range(1, 3);
        size  = 3'($urandom_range(0, 7));
        burst = 2'($urandom_range(0, 3));
        addr  = $urandom;
        case (kind)
            1: begin
                size = 3'($urandom_range(1, 7));
                mask = (32'd1 << size) - 32'd1;
                addr = (addr & ~mask) | 32'($urandom_range(1, int'(mask)));
            end
            2: begin
                if (burst == BURST_INCR)
                    burst = 2'd0;
                addr = addr & ~((32'd1 << size) - 32'd1);
            end
            default: begin
                if ((32'd1 << size) == BeatBytes)
                    size = 3'd0;
                burst = BURST_INCR;
                addr  = addr & ~((32'd1 << size) - 32'd1);
            end
        endcase
        add_tick(1'b1, addr, 8'($urandom), size, burst, 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic add_noise_tick(input logic v);
        add_tick(v, $urandom, 8'($urandom), 3'($urandom), 2'($urandom),
                 1'($urandom_range(0, 1)), 1'b0);
    endtask

    initial begin : stimulus
        int          n_random;
        int          n_bursts;
        int          len;
        int          r;
        int          beats;
        logic        rr;
        logic [31:0] addr;
        n_random = 0;
        n_bursts = 0;

        // ar_ready is still low right after reset, so this request is dropped
        add_tick(1'b1, 32'h0000_0100, 8'd3, 3'd2, BURST_INCR, 1'b1, 1'b0);
        add_tick(1'b1, 32'h0000_0101, 8'd0, 3'd2, BURST_INCR, 1'b0, 1'b0);
        // misalignment is reported ahead of a bad burst type
        add_tick(1'b1, 32'h0000_0040, 8'hff, 3'd7, 2'd0, 1'b1, 1'b0);
        add_tick(1'b1, 32'h0000_0010, 8'd0, 3'd2, 2'd0, 1'b0, 1'b0);
        // bad burst type is reported ahead of a narrow size
        add_tick(1'b1, 32'hffff_ffff, 8'd0, 3'd0, 2'd2, 1'b0, 1'b0);
        add_tick(1'b1, 32'h0000_0000, 8'd0, 3'd2, 2'd3, 1'b0, 1'b0);
        add_tick(1'b1, 32'h0000_0003, 8'd0, 3'd0, BURST_INCR, 1'b0, 1'b0);
        add_tick(1'b1, 32'h0000_0008, 8'd0, 3'd3, BURST_INCR, 1'b0, 1'b0);
        add_tick(1'b1, 32'hffff_ff80, 8'd0, 3'd7, BURST_INCR, 1'b0, 1'b0);
        add_tick(1'b0, 32'hffff_ffff, 8'hff, 3'd7, 2'd3, 1'b1, 1'b0);
        // three beats across the top of the address space
        add_tick(1'b1, 32'hffff_fff8, 8'd2, 3'd2, BURST_INCR, 1'b1, 1'b1);
        add_tick(1'b1, 32'h0000_0001, 8'hff, 3'd0, 2'd0, 1'b1, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b0, 1'b0);
        add_tick(1'b1, 32'h0, 8'd0, 3'd2, BURST_INCR, 1'b1, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0);
        // ar_ready is low for one tick after a burst ends
        add_tick(1'b1, 32'h0, 8'd0, 3'd2, BURST_INCR, 1'b0, 1'b0);
        // single beat, stalled once on the last beat
        add_tick(1'b1, 32'h0, 8'd0, 3'd2, BURST_INCR, 1'b0, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b0, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b0, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0);
        add_tick(1'b0, 32'h0, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0);

        // Random bursts with noise between them; the slave is idle with
        // ar_ready high at the top of each pass
        while (n_random < 650) begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1)) begin
                    add_bad_request();
                    n_random++;
                end else begin
                    add_noise_tick(1'b0);
                end
            end
            r = $urandom_range(0, 99);
            if (n_bursts == 0)
                len = 255;
            else if (r < 70)
                len = $urandom_range(0, 3);
            else if (r < 90)
                len = $urandom_range(4, 15);
            else if (r < 98)
                len = $urandom_range(16, 63);
            else
                len = $urandom_range(64, 255);
            if ($urandom_range(0, 99) < 15)
                addr = 32'hffff_ff00 | 32'($urandom_range(0, 63) << 2);
            else
                addr = $urandom & ~32'h3;
            add_tick(1'b1, addr, 8'(len), 3'd2, BURST_INCR, 1'($urandom_range(0, 1)),
                     n_bursts == 10 || n_bursts == 40);
            // r_valid rises one tick after the address is taken
            add_noise_tick(1'($urandom_range(0, 1)));
            n_random += 2;
            beats = 0;
            while (beats <= len) begin
                rr = ($urandom_range(0, 3) != 0);
                add_tick(1'($urandom_range(0, 1)), $urandom, 8'($urandom), 3'($urandom),
                         2'($urandom), rr, 1'b0);
                if (rr)
                    beats++;
                n_random++;
            end
            add_noise_tick(1'($urandom_range(0, 1)));
            n_bursts++;
        end
        n_ticks = tick_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_ticks)
            @(posedge i_clk);
        while (bus_outputs_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (n_errors == 0 && bus_outputs_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sender side
    always @(posedge i_clk) begin : drive_side
        t_stim nxt;
        logic  nxt_valid;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bus_outputs_q.push_back(step_read_slave(shown_tick));
                n_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tick_q.size() != 0 &&
                             !(tick_q[0].hold && bus_outputs_q.size() != 0)) begin
                    nxt        = tick_q.pop_front();
                    shown_tick = nxt.tick;
                    s_axis_tdata <= {1'b0, nxt.tick.mem_read_data, nxt.tick.r_ready,
                                     nxt.tick.ar_burst, nxt.tick.ar_size, nxt.tick.ar_len,
                                     nxt.tick.ar_addr, nxt.tick.ar_valid};
                    nxt_valid = 1'b1;
                    tx_calls++;
                    tx_gap = pick_gap((tx_calls % 256) >= 200);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Receiver side
    always @(posedge i_clk) begin : monitor_side
        t_tick_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bus_outputs_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = bus_outputs_q.pop_front();
                check_field("ar_ready", 32'(want.ar_ready), 32'(m_axis_tdata[0]));
                check_field("r_valid", 32'(want.r_valid), 32'(m_axis_tdata[1]));
                check_field("r_last", 32'(want.r_last), 32'(m_axis_tlast));
                check_field("r_data", want.r_data, m_axis_tdata[33:2]);
                check_field("mem_read_en", 32'(want.mem_read_en), 32'(m_axis_tdata[34]));
                check_field("mem_read_addr", want.mem_read_addr, m_axis_tdata[66:35]);
                check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[68:67]));
            end
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_calls++;
            rx_stall = pick_gap((rx_calls % 300) >= 220);
            m_axis_tready <= 1'b1;
        end
    end

endmodule

>>> axi_slave_read_burst.f
sv/axrb_pkg.sv
sv/axrb_addr_chk.sv
sv/axrb_beat_ctrl.sv
sv/axi_slave_read_burst.sv
sim/axi_slave_read_burst_test.sv
